// ===== rtl/pish_pkg.sv =====
// ---------------------------------------------------------------------------
// pish_pkg
// Shared types and constants for the point-in-shapes hit tester.
// ---------------------------------------------------------------------------
package pish_pkg;

  localparam int MaxShapes = 64;
  localparam int AddrW     = 6;
  localparam int CountW    = 7;
  localparam int CoordW    = 16;
  localparam int ThickW    = 15;
  localparam int EntryW    = 2 + 4 * CoordW + ThickW;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_CIRCLE = 2'd0,
    KIND_RECT   = 2'd1,
    KIND_SEG    = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] a;
    logic signed [CoordW-1:0] b;
    logic [ThickW-1:0]        t;
  } shape_t;

  // strobes from sequencer to the tester pipeline
  typedef struct packed {
    logic start;
    logic rd_valid;
  } test_ctl_t;

endpackage

// ===== rtl/pish_shape_ram.sv =====
// ---------------------------------------------------------------------------
// pish_shape_ram
// Shape table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module pish_shape_ram (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [pish_pkg::AddrW-1:0] waddr_i,
  input  pish_pkg::shape_t        wdata_i,
  input  logic [pish_pkg::AddrW-1:0] raddr_i,
  output pish_pkg::shape_t        rdata_o
);
  import pish_pkg::*;

  shape_t mem_q [MaxShapes];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/pish_shape_test.sv =====
// ---------------------------------------------------------------------------
// pish_shape_test
// Pipelined test of one shape against the query point, sticky hit flag.
// ---------------------------------------------------------------------------
module pish_shape_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pish_pkg::test_ctl_t        ctl_i,
  input  logic signed [pish_pkg::CoordW-1:0] qx_i,
  input  logic signed [pish_pkg::CoordW-1:0] qy_i,
  input  pish_pkg::shape_t           shape_i,
  output logic                       hit_o
);
  import pish_pkg::*;

  // stage 1 registers: differences and bounds
  logic        v1_q;
  kind_e       k1_q;
  logic [16:0] cdx_q, cdy_q, r_q;
  logic        rect_q, box_q, zlen_q;
  logic signed [16:0] sdx_q, sdy_q, pqx_q, pqy_q;
  logic [ThickW-1:0]  t1_q;
  // stage 2 registers: products
  logic        v2_q;
  kind_e       k2_q;
  logic        rect2_q, box2_q, zlen2_q;
  logic [34:0] circ_l_q;
  logic [33:0] r2_q;
  logic [34:0] len2_q;
  logic [29:0] t2_q;
  logic signed [34:0] c1_q, c2_q;
  // stage 3
  logic        v3_q;
  kind_e       k3_q;
  logic        box3_q, zlen3_q;
  logic [34:0] len3_q;
  logic [29:0] t3_q;
  logic [34:0] cr_q;
  logic        ok3_q;
  // stage 4
  logic        v4_q, seg4_q, ok4_q;
  logic [70:0] lhs_q;
  logic [64:0] rhs_q;
  logic        hit_q;

  logic signed [16:0] x, y, a, b, qx, qy, dxq, dyq, sdx, sdy;
  logic signed [17:0] xa, yb;
  logic signed [35:0] cdiff;
  logic [33:0]        sqx, sqy;
  logic signed [35:0] len_s;
  logic [69:0]        crsq;

  always_comb begin
    x   = 17'(shape_i.x);
    y   = 17'(shape_i.y);
    a   = 17'(shape_i.a);
    b   = 17'(shape_i.b);
    qx  = 17'(qx_i);
    qy  = 17'(qy_i);
    dxq = qx - x;
    dyq = qy - y;
    sdx = a - x;
    sdy = b - y;
    xa  = 18'(x) + 18'(a);
    yb  = 18'(y) + 18'(b);
    cdiff = 36'(c1_q) - 36'(c2_q);
    sqx   = cdx_q * cdx_q;
    sqy   = cdy_q * cdy_q;
    len_s = sdx_q * sdx_q + sdy_q * sdy_q;
    crsq  = cr_q * cr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.rd_valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (ctl_i.start) begin
        hit_q <= 1'b0;
      end else if (v4_q && (seg4_q ? (ok4_q && lhs_q <= 71'(rhs_q)) : ok4_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    // stage 1: differences, magnitudes, bounds
    k1_q   <= kind_e'(shape_i.kind);
    cdx_q  <= dxq[16] ? 17'(-dxq) : 17'(dxq);
    cdy_q  <= dyq[16] ? 17'(-dyq) : 17'(dyq);
    r_q    <= a[16] ? 17'(-a) : 17'(a);
    rect_q <= (18'(qx) >= 18'(x)) && (18'(qx) <= xa) &&
              (18'(qy) >= 18'(y)) && (18'(qy) <= yb);
    box_q  <= (qx >= ((x < a) ? x : a)) && (qx <= ((x < a) ? a : x)) &&
              (qy >= ((y < b) ? y : b)) && (qy <= ((y < b) ? b : y));
    zlen_q <= (sdx == 17'sd0) && (sdy == 17'sd0);
    sdx_q  <= sdx;
    sdy_q  <= sdy;
    pqx_q  <= dxq;
    pqy_q  <= dyq;
    t1_q   <= shape_i.t;
    // stage 2: squares and cross terms
    k2_q     <= k1_q;
    rect2_q  <= rect_q;
    box2_q   <= box_q;
    zlen2_q  <= zlen_q;
    circ_l_q <= 35'(sqx) + 35'(sqy);
    r2_q     <= r_q * r_q;
    len2_q   <= len_s[34:0];
    t2_q     <= t1_q * t1_q;
    c1_q     <= sdy_q * pqx_q;
    c2_q     <= sdx_q * pqy_q;
    // stage 3: cross product magnitude
    k3_q    <= k2_q;
    box3_q  <= box2_q;
    zlen3_q <= zlen2_q;
    len3_q  <= len2_q;
    t3_q    <= t2_q;
    cr_q    <= cdiff[35] ? 35'(-cdiff) : 35'(cdiff);
    // stage 4: segment products, or circle/rect decision carried
    seg4_q <= (k3_q == KIND_SEG);
    ok4_q  <= (k3_q == KIND_SEG) ? (box3_q && !zlen3_q) : ok3_q;
    lhs_q  <= {crsq[68:0], 2'b00};
    rhs_q  <= t3_q * len3_q;
  end

  // non-segment verdicts pass through a small side pipe
  always_ff @(posedge clk_i) begin
    ok3_q <= (k2_q == KIND_CIRCLE) ? (circ_l_q <= 35'(r2_q)) :
             (k2_q == KIND_RECT) ? rect2_q : 1'b0;
  end

  assign hit_o = hit_q;

endmodule

// ===== rtl/point_in_shapes_hit_test_unit.sv =====
// ---------------------------------------------------------------------------
// point_in_shapes_hit_test_unit
// Shape table with add, clear and point query; queries scan the table.
// ---------------------------------------------------------------------------
// add, clear, unused command: result written straight to the output register
// query: scans the table; one shape read from the table ram each cycle
// throughput: one transaction at a time, next accepted once result is taken
// reset clears the count and control; table contents stay undefined
module point_in_shapes_hit_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  shape_kind_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] ext_a_i,
  input  logic signed [15:0] ext_b_i,
  input  logic [14:0] thickness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        status_o,
  output logic [6:0]  shape_count_o
);
  import pish_pkg::*;

  state_e             state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  idx_q, idx_d;
  logic [2:0]         drain_q, drain_d;
  logic signed [CoordW-1:0] qx_q, qy_q;
  logic               ovalid_q, ovalid_d, ohit_d, ostat_d, ohit_q, ostat_q;
  logic               accept, we;
  shape_t             wdata, rdata;
  test_ctl_t          ctl;
  logic               hit;
  logic               rdv_q;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ovalid_q;
  assign we = accept && (cmd_e'(cmd_i) == CMD_ADD) && (count_q < CountW'(MaxShapes));
  assign wdata = '{kind: shape_kind_i, x: pos_x_i, y: pos_y_i,
                   a: ext_a_i, b: ext_b_i, t: thickness_i};

  pish_shape_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(wdata),
    .raddr_i(idx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  pish_shape_test u_test (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .qx_i  (qx_q),
    .qy_i  (qy_q),
    .shape_i(rdata),
    .hit_o (hit)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    drain_d  = drain_q;
    ovalid_d = ovalid_q && out_stall_i;
    ohit_d   = ohit_q;
    ostat_d  = ostat_q;
    ctl      = '{start: 1'b0, rd_valid: 1'b0};
    ctl.rd_valid = rdv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ohit_d  = 1'b0;
          ostat_d = 1'b0;
          unique case (cmd_e'(cmd_i))
            CMD_QUERY: begin
              ctl.start = 1'b1;
              idx_d     = '0;
              state_d   = ST_SCAN;
            end
            CMD_ADD: begin
              if (we) count_d = count_q + 1'b1;
              else    ostat_d = 1'b1;
              ovalid_d = 1'b1;
            end
            CMD_CLEAR: begin
              count_d  = '0;
              ovalid_d = 1'b1;
            end
            default: ovalid_d = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // idx is presented to the ram; data is valid in the next cycle
        if (idx_q < count_q) begin
          idx_d = idx_q + 1'b1;
        end else begin
          drain_d = 3'd0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 3'd5) begin
          ohit_d   = hit;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // read-valid strobe, valid in the cycle after its address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
    end else begin
      rdv_q <= (state_q == ST_SCAN) && (idx_q < count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      drain_q  <= '0;
      ovalid_q <= 1'b0;
      ohit_q   <= 1'b0;
      ostat_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      drain_q  <= drain_d;
      ovalid_q <= ovalid_d;
      ohit_q   <= ohit_d;
      ostat_q  <= ostat_d;
    end
  end

  // query point capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= pos_x_i;
      qy_q <= pos_y_i;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign hit_o         = ohit_q;
  assign status_o      = ostat_q;
  assign shape_count_o = count_q;

endmodule
